// ----- src/sha_pkg.sv -----
package sha_pkg;

  localparam int unsigned BlockWords  = 16;
  localparam int unsigned DigestWords = 8;
  localparam int unsigned Rounds      = 64;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_LOAD,
    S_ROUND,
    S_FINAL,
    S_OUT
  } state_t;

  // Controls for the compression datapath
  typedef struct packed {
    logic shift_h;   // shift hash data into the working variables
    logic load_w;    // shift a block word into the schedule window
    logic step;      // run one round
  } round_ctrl_t;

  function automatic logic [31:0] initial_hash(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h6a09e667;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
      default: r = 32'h428a2f98;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ----- src/sha_hash_mem.sv -----
module sha_hash_mem
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        we,
  input  logic [2:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [2:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0]            mem [DigestWords];
  logic [DigestWords-1:0] valid;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Track written entries; unwritten ones read as the initial hash
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (valid[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= initial_hash(raddr);
    end
  end

endmodule

// ----- src/sha_block_mem.sv -----
module sha_block_mem
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [BlockWords];

  // Write one big-endian block word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/sha_round_unit.sv -----
module sha_round_unit
  import sha_pkg::*;
(
  input  logic        clk,
  input  round_ctrl_t ctrl,
  input  logic [5:0]  rnd,
  input  logic [31:0] h_data,
  input  logic [31:0] w_data,
  output logic [31:0] v_head
);

  logic [31:0] v      [DigestWords];
  logic [31:0] w_line [BlockWords];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] w_new;

  // Round function on the working variables a..h
  always_comb begin
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + big_sigma1(v[4]) + ch + round_k(rnd) + w_line[0];
    t2    = big_sigma0(v[0]) + maj;
    w_new = w_line[0] + small_sigma0(w_line[1]) + w_line[9] + small_sigma1(w_line[14]);
  end

  // Working variables: shift in hash words, or advance one round
  always_ff @(posedge clk) begin
    if (ctrl.shift_h) begin
      for (int i = 0; i < DigestWords - 1; i++) begin
        v[i] <= v[i+1];
      end
      v[DigestWords-1] <= h_data;
    end else if (ctrl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // Schedule window: w_line[k] holds w[rnd + k]
  always_ff @(posedge clk) begin
    if (ctrl.load_w || ctrl.step) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_line[i] <= w_line[i+1];
      end
      w_line[BlockWords-1] <= ctrl.load_w ? w_data : w_new;
    end
  end

  assign v_head = v[0];

endmodule

// ----- src/sha256_byte_stream_hasher.sv -----
// A byte is taken in S_IDLE; the 64th byte of a block starts a compression
// (load, 64 rounds, hash update), one round per cycle in the round unit.
// A message end adds the pad bytes and the length, and one or two compressions,
// then eight digest words, each read through the registered hash memory read port.
// No new input byte is accepted while a block is compressed, padded or read out.
// Reset (rst, synchronous) empties the block and restores the initial hash.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    digest_valid,
  input  logic    digest_ready,
  output digest_t digest
);

  state_t      state;
  state_t      state_next;
  state_t      ret_state;
  state_t      ret_next;
  state_t      after;
  logic [5:0]  fill;
  logic [23:0] acc;
  logic [63:0] bit_count;
  logic [4:0]  cnt;
  logic [5:0]  rnd;
  logic [2:0]  lcnt;
  logic [2:0]  ocnt;
  logic [2:0]  ridx;
  logic        rd_pending;
  logic        put;
  logic [7:0]  put_byte;
  logic        take;
  logic        issue;
  logic        restart;
  round_ctrl_t rctrl;
  logic [2:0]  h_raddr;
  logic [31:0] h_rdata;
  logic        h_we;
  logic [31:0] w_rdata;
  logic [31:0] v_head;

  assign take  = item_valid && item_ready;
  assign issue = (state == S_OUT) && !digest_valid && !rd_pending;

  // Next state and byte-path control
  always_comb begin
    state_next = state;
    ret_next   = ret_state;
    after      = state;
    put        = 1'b0;
    put_byte   = 8'd0;
    item_ready = 1'b0;
    restart    = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        after      = item.end_of_message ? S_PAD_MARK : S_IDLE;
        if (take) begin
          put        = item.has_byte;
          put_byte   = item.msg_byte;
          state_next = after;
        end
      end
      S_PAD_MARK: begin
        put        = 1'b1;
        put_byte   = PAD_MARKER;
        after      = S_PAD_ZERO;
        state_next = after;
      end
      S_PAD_ZERO: begin
        if (fill == LENGTH_POS) begin
          state_next = S_PAD_LEN;
        end else begin
          put        = 1'b1;
          after      = S_PAD_ZERO;
          state_next = after;
        end
      end
      S_PAD_LEN: begin
        put        = 1'b1;
        put_byte   = bit_count[{~lcnt, 3'b000} +: 8];
        after      = (lcnt == 3'd7) ? S_OUT : S_PAD_LEN;
        state_next = after;
      end
      S_LOAD: begin
        if (cnt == 5'(BlockWords)) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (rnd == 6'(Rounds - 1)) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (cnt == 5'(DigestWords)) begin
          state_next = ret_state;
        end
      end
      S_OUT: begin
        if (issue && ocnt == 3'(DigestWords - 1)) begin
          restart    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // A full block diverts to compression, then resumes
    if (put && fill == FILL_LAST) begin
      state_next = S_LOAD;
      ret_next   = after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
    end
  end

  // Byte position, bit count and pad length index
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      fill      <= '0;
      bit_count <= '0;
      lcnt      <= '0;
    end else begin
      if (put) begin
        fill <= fill + 6'd1;
      end
      if (take && item.has_byte) begin
        bit_count <= bit_count + 64'd8;
      end
      if (state == S_PAD_LEN) begin
        lcnt <= lcnt + 3'd1;
      end
    end
  end

  // Assemble bytes into a block word
  always_ff @(posedge clk) begin
    if (put) begin
      acc <= {acc[15:0], put_byte};
    end
  end

  // Phase counters for load, rounds and hash update
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rnd <= '0;
    end else begin
      cnt <= (state_next == state) ? cnt + 5'd1 : 5'd0;
      rnd <= (state == S_ROUND) ? rnd + 6'd1 : 6'd0;
    end
  end

  // Datapath controls
  always_comb begin
    rctrl.load_w  = (state == S_LOAD) && (cnt != 5'd0);
    rctrl.shift_h = ((state == S_LOAD) && (cnt != 5'd0) && (cnt <= 5'(DigestWords)))
                 || ((state == S_FINAL) && (cnt != 5'd0));
    rctrl.step    = (state == S_ROUND);
    h_we          = (state == S_FINAL) && (cnt != 5'd0);
    h_raddr       = (state == S_OUT) ? ocnt : cnt[2:0];
  end

  sha_block_mem u_block (
    .clk   (clk),
    .we    (put && fill[1:0] == 2'd3),
    .waddr (fill[5:2]),
    .wdata ({acc, put_byte}),
    .raddr (cnt[3:0]),
    .rdata (w_rdata)
  );

  sha_hash_mem u_hash (
    .clk   (clk),
    .rst   (rst),
    .clear (restart),
    .we    (h_we),
    .waddr (3'(cnt - 5'd1)),
    .wdata (h_rdata + v_head),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  sha_round_unit u_round (
    .clk    (clk),
    .ctrl   (rctrl),
    .rnd    (rnd),
    .h_data (h_rdata),
    .w_data (w_rdata),
    .v_head (v_head)
  );

  // Digest output register: read a hash word, then hold it for transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
      rd_pending   <= 1'b0;
      ocnt         <= '0;
    end else begin
      rd_pending <= issue;
      if (issue) begin
        ocnt <= ocnt + 3'd1;
      end
      if (rd_pending) begin
        digest_valid <= 1'b1;
      end else if (digest_ready) begin
        digest_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ridx <= ocnt;
    end
    if (rd_pending) begin
      digest.digest_word <= h_rdata;
      digest.word_index  <= ridx;
      digest.last_word   <= (ridx == 3'(DigestWords - 1));
    end
  end

endmodule

// ----- src/sha_checker.sv -----
module sha_checker
  import sha_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    digest_valid,
  input logic    digest_ready,
  input digest_t digest
);

  // Hold a stalled digest word
  a_hold : assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest))
    else $error("digest word changed while stalled");

  // Flag the final word exactly at index seven
  a_last : assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (digest.last_word == (digest.word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // Drop input acceptance while padding follows a message end
  a_pad : assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.end_of_message |=> !item_ready)
    else $error("input accepted right after message end");

  // Hold off input until the whole digest is read out
  a_drain : assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !digest.last_word |=> !item_ready)
    else $error("input accepted in the middle of a digest");

  // Start empty after reset
  a_reset : assert property (@(posedge clk)
    rst |=> !digest_valid)
    else $error("digest valid after reset");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .digest_valid (digest_valid),
  .digest_ready (digest_ready),
  .digest       (digest)
);

// ----- bench/sha256_byte_stream_hasher_checker.sv -----
module sha256_byte_stream_hasher_checker
  import sha_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    digest_valid,
  input  logic    digest_ready,
  input  digest_t digest,
  output int      fail_count,
  output int      words_outstanding
);

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LENGTH_SLOT = 6'd56;

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] START_CHAIN = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Shadow copy of the hashing state
  logic [31:0] chain [8];
  logic [7:0]  block_bytes [64];
  logic [63:0] bit_length;
  logic [5:0]  fill;

  // Expected digest words, oldest at rd_ptr
  digest_t     expect_fifo [64];
  logic [5:0]  wr_ptr = '0;
  logic [5:0]  rd_ptr = '0;
  int          mismatches = 0;
  int          pending_words = 0;

  assign fail_count        = mismatches;
  assign words_outstanding = pending_words;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = START_CHAIN[i];
    bit_length = '0;
    fill = '0;
  endtask

  // Run the 64 rounds over the held block and fold into the chaining value
  task automatic compress_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                  block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      sched[i] = sched[i-16] + sched[i-7]
               + (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + sched[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    block_bytes[fill] = b;
    fill = fill + 6'd1;
    if (fill == '0) compress_block();
  endtask

  // Take the byte, then on a message end pad, finish and queue the eight words
  task automatic absorb_item(input item_t it);
    logic [63:0] len;
    if (it.has_byte) begin
      bit_length = bit_length + 64'd8;
      absorb_byte(it.msg_byte);
    end
    if (it.end_of_message) begin
      len = bit_length;
      absorb_byte(PAD_BYTE);
      while (fill != LENGTH_SLOT) absorb_byte(8'h00);
      for (int k = 0; k < 8; k++) absorb_byte(len[8*(7-k) +: 8]);
      for (int k = 0; k < 8; k++) begin
        expect_fifo[wr_ptr] = '{digest_word: chain[k],
                                word_index: 3'(k),
                                last_word: (k == 7)};
        wr_ptr = wr_ptr + 6'd1;
        pending_words = pending_words + 1;
      end
      restart_message();
    end
  endtask

  // Follow both channels and compare each digest transfer with the oldest expectation
  always @(posedge clk) begin
    digest_t want;
    if (rst) begin
      restart_message();
      wr_ptr = '0;
      rd_ptr = '0;
      pending_words = 0;
    end else begin
      if (digest_valid && digest_ready) begin
        if (pending_words == 0) begin
          $error("digest word %h arrived with none expected", digest.digest_word);
          mismatches++;
        end else begin
          want = expect_fifo[rd_ptr];
          rd_ptr = rd_ptr + 6'd1;
          pending_words = pending_words - 1;
          if (digest.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word, digest.digest_word);
            mismatches++;
          end
          if (digest.word_index !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index, digest.word_index);
            mismatches++;
          end
          if (digest.last_word !== want.last_word) begin
            $error("last_word: expected %b, got %b", want.last_word, digest.last_word);
            mismatches++;
          end
        end
      end
      if (item_valid && item_ready) absorb_item(item);
    end
  end

endmodule

// ----- bench/sha256_byte_stream_hasher_tb.sv -----
module sha256_byte_stream_hasher_tb;
  import sha_pkg::*;

  localparam int HOLD_CYCLES    = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int PHASE_ITEMS    = 30;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    digest_valid;
  logic    digest_ready;
  digest_t digest;

  int   fail_count;
  int   words_outstanding;
  int   send_idle_pct = 9;
  int   recv_stall_pct = 76;
  int   items_sent = 0;
  logic hold_pending = 1'b0;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready),
    .digest      (digest)
  );

  sha256_byte_stream_hasher_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .item             (item),
    .digest_valid     (digest_valid),
    .digest_ready     (digest_ready),
    .digest           (digest),
    .fail_count       (fail_count),
    .words_outstanding(words_outstanding)
  );

  // Idle at random, then offer one item and hold it until the transfer
  task automatic send_item(input logic [7:0] b, input logic has, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{msg_byte: b, has_byte: has, end_of_message: eom};
    do @(posedge clk); while (!item_ready);
    if (has || eom) items_sent++;
  endtask

  // Send len random bytes; close either on the last byte or with a bare end
  task automatic send_message(input int len);
    logic close_on_byte;
    close_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Favor short messages and lengths around the padding boundaries
  function automatic int pick_length();
    int r;
    int boundary [7];
    boundary = '{0, 55, 56, 63, 64, 119, 120};
    r = $urandom_range(99);
    if (r < 35) return $urandom_range(8);
    if (r < 70) return boundary[$urandom_range(6)];
    return $urandom_range(130);
  endfunction

  // Drop valid and hold off until every expected word has come back
  task automatic pause_until_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (words_outstanding != 0);
    @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    int start_items;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start_items = items_sent;
    while (items_sent - start_items < PHASE_ITEMS) begin
      send_message(pick_length());
    end
    pause_until_drained();
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    digest_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        digest_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      digest_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run after too long without any transfer
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (digest_valid && digest_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored item, empty messages, extreme bytes, byte with end
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hfe, 1'b1, 1'b1);
    send_item(8'h33, 1'b0, 1'b0);
    send_item(8'hc3, 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    pause_until_drained();

    run_phase(9, 76);
    run_phase(76, 9);

    // Stall the receiver while short messages are offered, so the input backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_pending = 1'b1;
    for (int i = 0; i < 6; i++) send_message($urandom_range(1, 3));
    pause_until_drained();

    run_phase(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
